### rtl/core/sas_pkg.sv
// ----------------------------------------------------------------------------
// Sprite animation sequencer package
// Shared constants, codes, state types and helpers of the frame sequencer.
// ----------------------------------------------------------------------------
package sas_pkg;

  localparam int unsigned MaxFramesDef = 16;
  localparam int unsigned NumStatesDef = 6;
  localparam int unsigned NumDirsDef   = 4;

  localparam int unsigned LenW   = 5;
  localparam int unsigned DurW   = 24;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned SpeedW = 16;
  localparam int unsigned ProdW  = DurW + SpeedW;

  localparam logic [SpeedW-1:0] SpeedReset = 16'd256;
  localparam logic [SpeedW-1:0] SpeedUnity = 16'd256;
  localparam logic [DurW-1:0]   DurMinKeep = 24'd66;
  localparam logic [DurW-1:0]   DurDefault = 24'd6554;

  typedef enum logic [2:0] {
    OP_LOAD_CLIP = 3'd0,
    OP_LOAD_DUR  = 3'd1,
    OP_PLAY      = 3'd2,
    OP_TICK      = 3'd3,
    OP_PAUSE     = 3'd4,
    OP_RESUME    = 3'd5,
    OP_REWIND    = 3'd6
  } sas_op_e;

  typedef enum logic [1:0] {
    MODE_PLAYING  = 2'd0,
    MODE_PAUSED   = 2'd1,
    MODE_FINISHED = 2'd2
  } sas_mode_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_TADD,
    S_RD,
    S_CMP,
    S_SUMRD,
    S_SUM,
    S_DIVGO,
    S_DIV,
    S_RESULT
  } sas_state_e;

  typedef struct packed {
    logic       found;
    logic [2:0] st;
    logic [1:0] dir;
  } sas_hit_t;

  // Short stored durations stand for the default of one tenth of a second.
  function automatic logic [DurW-1:0] eff_dur(input logic [DurW-1:0] v);
    eff_dur = (v < DurMinKeep) ? DurDefault : v;
  endfunction

endpackage

### rtl/core/sas_item_if.sv
// ----------------------------------------------------------------------------
// Item channel
// Valid/ready channel carrying one command beat into the sequencer.
// ----------------------------------------------------------------------------
interface sas_item_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [2:0]  anim_state;
  logic [1:0]  direction;
  logic [3:0]  frame_index;
  logic [4:0]  clip_length;
  logic        looping;
  logic [23:0] duration;
  logic        restart;
  logic [23:0] delta;

  modport source (output valid, operation, anim_state, direction, frame_index, clip_length,
                  looping, duration, restart, delta, input ready);
  modport sink (input valid, operation, anim_state, direction, frame_index, clip_length,
                looping, duration, restart, delta, output ready);
endinterface

### rtl/core/sas_result_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one status beat out of the sequencer.
// ----------------------------------------------------------------------------
interface sas_result_if;
  logic       valid;
  logic       ready;
  logic       ok;
  logic [2:0] current_anim_state;
  logic [1:0] current_direction;
  logic [3:0] held_frame;
  logic [1:0] playback;

  modport source (output valid, ok, current_anim_state, current_direction, held_frame,
                  playback, input ready);
  modport sink (input valid, ok, current_anim_state, current_direction, held_frame,
                playback, output ready);
endinterface

### rtl/core/sas_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration channel
// Valid/ready write channel for the playback speed register.
// ----------------------------------------------------------------------------
interface sas_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### rtl/core/sas_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sas_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/sas_search.sv
// ----------------------------------------------------------------------------
// Clip search
// Resolves a requested state and direction to a loaded clip by fallback order.
// ----------------------------------------------------------------------------
module sas_search import sas_pkg::*; #(
  parameter int unsigned NumStates = NumStatesDef,
  parameter int unsigned NumDirs   = NumDirsDef,
  localparam int unsigned NumClips = NumStates * NumDirs
) (
  input  logic [NumClips-1:0] valid_i,
  input  logic [2:0]          st_i,
  input  logic [1:0]          dir_i,
  output sas_hit_t            hit_o
);

  logic     st_ok, dir_ok;
  logic     exact, idle_dir, sfound, afound;
  logic [1:0] sdir;
  logic [2:0] ast;
  logic [1:0] adir;

  always_comb begin
    st_ok  = 32'(st_i) < NumStates;
    dir_ok = 32'(dir_i) < NumDirs;
    exact  = 1'b0;
    if (st_ok && dir_ok) begin
      exact = valid_i[32'(st_i) * NumDirs + 32'(dir_i)];
    end
    idle_dir = 1'b0;
    if (dir_ok) begin
      idle_dir = valid_i[32'(dir_i)];
    end
    // Lowest direction of the requested state wins.
    sfound = 1'b0;
    sdir   = 2'd0;
    for (int j = NumDirs - 1; j >= 0; j--) begin
      if (st_ok && valid_i[32'(st_i) * NumDirs + 32'(j)]) begin
        sfound = 1'b1;
        sdir   = 2'(j);
      end
    end
    afound = 1'b0;
    ast    = 3'd0;
    adir   = 2'd0;
    for (int i = NumClips - 1; i >= 0; i--) begin
      if (valid_i[i]) begin
        afound = 1'b1;
        ast    = 3'(i / NumDirs);
        adir   = 2'(i % NumDirs);
      end
    end

    hit_o.found = 1'b1;
    hit_o.st    = st_i;
    hit_o.dir   = dir_i;
    if (exact) begin
      hit_o.found = 1'b1;
    end else if (sfound) begin
      hit_o.dir = sdir;
    end else if (idle_dir) begin
      hit_o.st = 3'd0;
    end else if (valid_i[0]) begin
      hit_o.st  = 3'd0;
      hit_o.dir = 2'd0;
    end else if (afound) begin
      hit_o.st  = ast;
      hit_o.dir = adir;
    end else begin
      hit_o.found = 1'b0;
    end
  end

endmodule

### rtl/core/sas_mod.sv
// ----------------------------------------------------------------------------
// Remainder unit
// Restoring bit-serial remainder of a 32-bit value, one bit per cycle.
// ----------------------------------------------------------------------------
module sas_mod import sas_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [TimeW-1:0] num_i,
  input  logic [TimeW-1:0] den_i,
  output logic             done_o,
  output logic [TimeW-1:0] rem_o
);

  logic [TimeW:0]   rem_q, rem_d, trial;
  logic [TimeW-1:0] num_q, num_d, den_q, den_d;
  logic [5:0]       cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;

  always_comb begin
    rem_d  = rem_q;
    num_d  = num_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[TimeW-1:0], num_q[TimeW-1]};
    if (start_i) begin
      rem_d  = '0;
      num_d  = num_i;
      den_d  = den_i;
      cnt_d  = 6'(TimeW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = (trial >= {1'b0, den_q}) ? trial - {1'b0, den_q} : trial;
      num_d = {num_q[TimeW-2:0], 1'b0};
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[TimeW-1:0];

endmodule

### rtl/core/sprite_animation_sequencer.sv
// ----------------------------------------------------------------------------
// Sprite animation sequencer
// Clip table, frame duration memory and the tick frame walk.
// ----------------------------------------------------------------------------
// Commands arrive as beats on item_i and each gives exactly one status beat on
// result_o. cfg_i is always ready and writes the playback speed; the user must
// write it only while the block is idle, which the block does not enforce.
// Loads, play, pause, resume, rewind and a tick that is not playing or finds
// no clip go from acceptance straight to the result state, which fills the
// result register. Any other tick loads the clip length and adds the scaled
// delta, then reads the duration memory once per frame stepped; the first
// wrap of a looping clip in a tick also reads every clip frame to sum the
// loop time and runs the bit-serial remainder unit. After reset the
// NumStates*NumDirs*MaxFrames duration entries (384 by default) are cleared,
// one entry a cycle, and item_i stays low-ready meanwhile. The result
// register holds its beat while the receiver stalls; the next item is then
// taken and worked on, but its result waits until the register is free.
// ----------------------------------------------------------------------------
module sprite_animation_sequencer import sas_pkg::*; #(
  parameter int unsigned MaxFrames = MaxFramesDef,
  parameter int unsigned NumStates = NumStatesDef,
  parameter int unsigned NumDirs   = NumDirsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  sas_item_if.sink     item_i,
  sas_result_if.source result_o,
  sas_cfg_if.sink      cfg_i
);

  localparam int unsigned NumClips = NumStates * NumDirs;
  localparam int unsigned Entries  = NumClips * MaxFrames;
  localparam int unsigned CW = (NumClips > 1) ? $clog2(NumClips) : 1;
  localparam int unsigned AW = (Entries > 1) ? $clog2(Entries) : 1;

  sas_state_e state_q, state_d;

  logic [SpeedW-1:0] speed_q;
  logic [NumClips-1:0] valid_q, valid_d;
  logic [2:0]        cur_st_q, cur_st_d;
  logic [1:0]        cur_dir_q, cur_dir_d;
  logic [LenW-1:0]   cur_frame_q, cur_frame_d;
  logic [TimeW-1:0]  elapsed_q, elapsed_d;
  sas_mode_e         mode_q, mode_d;
  logic              ok_q, ok_d;
  logic [AW-1:0]     clr_q, clr_d;

  logic [CW-1:0]     clip_q, clip_d;
  logic [ProdW-1:0]  prod_q, prod_d;
  logic [LenW-1:0]   n_q, n_d, f_q, f_d, k_q, k_d, fn;
  logic              loops_q, loops_d, wrapped_q, wrapped_d;
  logic [TimeW-1:0]  e_q, e_d, total_q, total_d;
  logic [TimeW:0]    sum;
  logic [DurW-1:0]   dur;

  logic              out_valid_q, out_valid_d, out_ok_q;
  logic [2:0]        out_st_q;
  logic [1:0]        out_dir_q;
  logic [3:0]        out_frame_q;
  logic [1:0]        out_mode_q;

  // Memory ports
  logic              d_we;
  logic [CW-1:0]     d_waddr, d_raddr;
  logic [LenW:0]     d_wdata, d_rdata;
  logic              f_we;
  logic [AW-1:0]     f_waddr, f_raddr;
  logic [DurW-1:0]   f_wdata, f_rdata;

  logic              div_start, div_done;
  logic [TimeW-1:0]  div_rem;

  logic [2:0]        s_st;
  logic [1:0]        s_dir;
  sas_hit_t          hit;

  logic              accept, in_tab, clip_ok, dur_ok, out_free;
  logic [CW-1:0]     in_clip, hit_clip;
  sas_op_e           op;

  assign accept   = item_i.valid && item_i.ready;
  assign op       = sas_op_e'(item_i.operation);
  assign out_free = !out_valid_q || result_o.ready;
  assign in_tab   = (32'(item_i.anim_state) < NumStates) && (32'(item_i.direction) < NumDirs);
  assign clip_ok  = in_tab && (item_i.clip_length != '0) && (32'(item_i.clip_length) <= MaxFrames);
  assign dur_ok   = in_tab && (32'(item_i.frame_index) < MaxFrames);
  assign in_clip  = CW'(32'(item_i.anim_state) * NumDirs + 32'(item_i.direction));
  assign hit_clip = CW'(32'(hit.st) * NumDirs + 32'(hit.dir));

  // Play searches for the requested clip, tick for the held one.
  assign s_st  = (op == OP_PLAY) ? item_i.anim_state : cur_st_q;
  assign s_dir = (op == OP_PLAY) ? item_i.direction : cur_dir_q;

  sas_search #(.NumStates(NumStates), .NumDirs(NumDirs)) u_search (
    .valid_i (valid_q),
    .st_i    (s_st),
    .dir_i   (s_dir),
    .hit_o   (hit)
  );

  sas_ram #(.Width(LenW + 1), .Depth(NumClips)) u_desc_ram (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .waddr_i (d_waddr),
    .wdata_i (d_wdata),
    .raddr_i (d_raddr),
    .rdata_o (d_rdata)
  );

  sas_ram #(.Width(DurW), .Depth(Entries)) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (f_waddr),
    .wdata_i (f_wdata),
    .raddr_i (f_raddr),
    .rdata_o (f_rdata)
  );

  sas_mod u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (e_q),
    .den_i   (total_q),
    .done_o  (div_done),
    .rem_o   (div_rem)
  );

  assign dur = eff_dur(f_rdata);
  assign fn  = f_q + LenW'(1);
  assign sum = {1'b0, elapsed_q} + {1'b0, prod_q[ProdW-1:8]};

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (32'(clr_q) == Entries - 1) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (op == OP_TICK && mode_q == MODE_PLAYING && hit.found) state_d = S_TADD;
          else state_d = S_RESULT;
        end
      end
      S_TADD: state_d = S_RD;
      S_RD:   state_d = S_CMP;
      S_CMP: begin
        if (e_q < 32'(dur)) begin
          state_d = S_RESULT;
        end else if (fn >= n_q) begin
          if (!loops_q) state_d = S_RESULT;
          else if (!wrapped_q) state_d = S_SUMRD;
          else state_d = S_RD;
        end else begin
          state_d = S_RD;
        end
      end
      S_SUMRD: state_d = S_SUM;
      S_SUM: begin
        if (k_q + LenW'(1) == n_q) state_d = S_DIVGO;
        else state_d = S_SUMRD;
      end
      S_DIVGO: state_d = S_DIV;
      S_DIV: begin
        if (div_done) state_d = S_RD;
      end
      S_RESULT: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    valid_d     = valid_q;
    cur_st_d    = cur_st_q;
    cur_dir_d   = cur_dir_q;
    cur_frame_d = cur_frame_q;
    elapsed_d   = elapsed_q;
    mode_d      = mode_q;
    ok_d        = ok_q;
    clr_d       = clr_q;
    clip_d      = clip_q;
    prod_d      = prod_q;
    n_d         = n_q;
    loops_d     = loops_q;
    f_d         = f_q;
    k_d         = k_q;
    e_d         = e_q;
    wrapped_d   = wrapped_q;
    total_d     = total_q;
    out_valid_d = out_valid_q && !result_o.ready;
    d_we        = 1'b0;
    d_waddr     = in_clip;
    d_wdata     = {item_i.looping, item_i.clip_length};
    d_raddr     = hit_clip;
    f_we        = 1'b0;
    f_waddr     = AW'(32'(in_clip) * MaxFrames + 32'(item_i.frame_index));
    f_wdata     = item_i.duration;
    f_raddr     = (state_q == S_SUMRD) ? AW'(32'(clip_q) * MaxFrames + 32'(k_q))
                                       : AW'(32'(clip_q) * MaxFrames + 32'(f_q));
    div_start   = 1'b0;

    case (state_q)
      S_CLEAR: begin
        f_we    = 1'b1;
        f_waddr = clr_q;
        f_wdata = '0;
        clr_d   = clr_q + AW'(1);
      end
      S_IDLE: begin
        if (accept) begin
          ok_d = 1'b0;
          case (op)
            OP_LOAD_CLIP: begin
              if (clip_ok) begin
                d_we             = 1'b1;
                valid_d[in_clip] = 1'b1;
                ok_d             = 1'b1;
              end
            end
            OP_LOAD_DUR: begin
              if (dur_ok) begin
                f_we = 1'b1;
                ok_d = 1'b1;
              end
            end
            OP_PLAY: begin
              if (!hit.found) begin
                cur_st_d    = item_i.anim_state;
                cur_dir_d   = item_i.direction;
                cur_frame_d = '0;
                elapsed_d   = '0;
                mode_d      = MODE_FINISHED;
              end else begin
                ok_d = 1'b1;
                if (item_i.restart || cur_st_q != hit.st || cur_dir_q != hit.dir ||
                    mode_q != MODE_PLAYING) begin
                  cur_st_d    = hit.st;
                  cur_dir_d   = hit.dir;
                  cur_frame_d = '0;
                  elapsed_d   = '0;
                  mode_d      = MODE_PLAYING;
                end
              end
            end
            OP_TICK: begin
              clip_d = hit_clip;
              prod_d = ProdW'(item_i.delta) *
                       ProdW'((speed_q == '0) ? SpeedUnity : speed_q);
            end
            OP_PAUSE: begin
              if (mode_q == MODE_PLAYING) mode_d = MODE_PAUSED;
            end
            OP_RESUME: begin
              if (mode_q == MODE_PAUSED) mode_d = MODE_PLAYING;
            end
            OP_REWIND: begin
              cur_frame_d = '0;
              elapsed_d   = '0;
              mode_d      = MODE_PLAYING;
            end
            default: ok_d = 1'b0;
          endcase
        end
      end
      S_TADD: begin
        n_d       = d_rdata[LenW-1:0];
        loops_d   = d_rdata[LenW];
        e_d       = sum[TimeW] ? '1 : sum[TimeW-1:0];
        f_d       = (cur_frame_q >= d_rdata[LenW-1:0]) ? '0 : cur_frame_q;
        wrapped_d = 1'b0;
      end
      S_CMP: begin
        if (e_q < 32'(dur)) begin
          cur_frame_d = f_q;
          elapsed_d   = e_q;
        end else begin
          e_d = e_q - 32'(dur);
          f_d = fn;
          if (fn >= n_q) begin
            if (loops_q) begin
              f_d = '0;
              if (!wrapped_q) begin
                wrapped_d = 1'b1;
                total_d   = '0;
                k_d       = '0;
              end
            end else begin
              cur_frame_d = n_q - LenW'(1);
              elapsed_d   = '0;
              mode_d      = MODE_FINISHED;
            end
          end
        end
      end
      S_SUM: begin
        total_d = total_q + 32'(dur);
        k_d     = k_q + LenW'(1);
      end
      S_DIVGO: div_start = 1'b1;
      S_DIV: begin
        if (div_done) e_d = div_rem;
      end
      S_RESULT: begin
        if (out_free) out_valid_d = 1'b1;
      end
      default: clr_d = clr_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      speed_q     <= SpeedReset;
      valid_q     <= '0;
      cur_st_q    <= '0;
      cur_dir_q   <= '0;
      cur_frame_q <= '0;
      elapsed_q   <= '0;
      mode_q      <= MODE_PLAYING;
      ok_q        <= 1'b0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      cur_st_q    <= cur_st_d;
      cur_dir_q   <= cur_dir_d;
      cur_frame_q <= cur_frame_d;
      elapsed_q   <= elapsed_d;
      mode_q      <= mode_d;
      ok_q        <= ok_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid) begin
        speed_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    clip_q    <= clip_d;
    prod_q    <= prod_d;
    n_q       <= n_d;
    loops_q   <= loops_d;
    f_q       <= f_d;
    k_q       <= k_d;
    e_q       <= e_d;
    wrapped_q <= wrapped_d;
    total_q   <= total_d;
    if (state_q == S_RESULT && out_free) begin
      out_ok_q    <= ok_q;
      out_st_q    <= cur_st_q;
      out_dir_q   <= cur_dir_q;
      out_frame_q <= cur_frame_q[3:0];
      out_mode_q  <= mode_q;
    end
  end

  assign item_i.ready                = (state_q == S_IDLE);
  assign cfg_i.ready                 = 1'b1;
  assign result_o.valid              = out_valid_q;
  assign result_o.ok                 = out_ok_q;
  assign result_o.current_anim_state = out_st_q;
  assign result_o.current_direction  = out_dir_q;
  assign result_o.held_frame         = out_frame_q;
  assign result_o.playback           = out_mode_q;

endmodule
